// File: hw/rtl/gregorian_date_offset_and_difference_core_macros.svh
// ----------------------------------------------------------------------------
// Gregorian date core assertion macros
// Clocked, reset-gated property wrappers shared by the date core.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_OFFSET_AND_DIFFERENCE_CORE_MACROS_SVH
`define GREGORIAN_DATE_OFFSET_AND_DIFFERENCE_CORE_MACROS_SVH

// same-cycle implication
`define GDOD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GDOD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/gdod_pkg.sv
// ----------------------------------------------------------------------------
// gdod_pkg
// Types, calendar constants and table functions of the Gregorian date core.
// ----------------------------------------------------------------------------
package gdod_pkg;

  // day accumulator width (signed), holds day numbers since 0000-01-01 +/- offset
  localparam int ACC_W = 24;

  localparam logic [11:0] MIN_YEAR  = 12'd1900;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  localparam logic [11:0] YEARS_400 = 12'd400;
  localparam logic [11:0] YEARS_100 = 12'd100;
  localparam logic [11:0] YEARS_4   = 12'd4;

  localparam logic signed [ACC_W-1:0] DAYS_400Y       = 24'sd146097;
  localparam logic signed [ACC_W-1:0] DAYS_CENT_LONG  = 24'sd36525;
  localparam logic signed [ACC_W-1:0] DAYS_CENT_SHORT = 24'sd36524;
  localparam logic signed [ACC_W-1:0] DAYS_4Y_LONG    = 24'sd1461;
  localparam logic signed [ACC_W-1:0] DAYS_4Y_SHORT   = 24'sd1460;
  localparam logic signed [ACC_W-1:0] DAYS_LEAP_YEAR  = 24'sd366;
  localparam logic signed [ACC_W-1:0] DAYS_YEAR       = 24'sd365;

  localparam logic signed [ACC_W-1:0] DIFF_MAX = 24'sd1048575;
  localparam logic signed [ACC_W-1:0] DIFF_MIN = -24'sd1048576;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_Y400 = 16'h0002,
    S_Y100 = 16'h0004,
    S_Y4   = 16'h0008,
    S_Y1   = 16'h0010,
    S_MD   = 16'h0020,
    S_OFF  = 16'h0040,
    S_LO   = 16'h0080,
    S_HI   = 16'h0100,
    S_SUB  = 16'h0200,
    S_D400 = 16'h0400,
    S_D100 = 16'h0800,
    S_D4   = 16'h1000,
    S_D1   = 16'h2000,
    S_DMON = 16'h4000,
    S_DONE = 16'h8000
  } state_t;

  // days from 0000-01-01 to the first of year y (proleptic Gregorian), elaboration only
  function automatic int days_to_year(input int y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // length of month m, zero for a month outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/gdod_alu.sv
// ----------------------------------------------------------------------------
// gdod_alu
// Shared signed add/subtract unit of the date core; sign gives the compare.
// ----------------------------------------------------------------------------
module gdod_alu
  import gdod_pkg::*;
(
  input  alu_op_t                 op,
  input  logic signed [ACC_W-1:0] a,
  input  logic signed [ACC_W-1:0] b,
  output logic signed [ACC_W-1:0] res,
  output logic                    neg
);

  always_comb begin
    if (op == ALU_SUB) begin
      res = a - b;
    end else begin
      res = a + b;
    end
    neg = res[ACC_W-1];
  end

endmodule

// File: hw/rtl/gregorian_date_offset_and_difference_core.sv
// ----------------------------------------------------------------------------
// Sequencing: each item is a year/month walk of the shared adder: one 400-year,
// century, 4-year, year or month step per cycle, two date conversions for op 1.
// Throughput: one item at a time; a new item is taken in the cycle after the
// result is parked in the output register. rst (sync, active high) clears
// sequencer and output valid; no clearing pass.
// ----------------------------------------------------------------------------
// gregorian_date_offset_and_difference_core
// Gregorian date arithmetic: move date A by a signed day count (op 0) or give
// the day difference A minus B (op 1), plus compare and validity flags.
// ----------------------------------------------------------------------------
`include "gregorian_date_offset_and_difference_core_macros.svh"

module gregorian_date_offset_and_difference_core
  import gdod_pkg::*;
#(
  parameter int MAX_YEAR = 4095
) (
  input  logic        clk,
  input  logic        rst,
  // input item
  input  logic        s_tvalid,
  output logic        s_tready,
  // a_year[11:0] a_month[15:12] a_day[20:16] b_year[32:21] b_month[36:33]
  // b_day[41:37] offset_days[62:42] zero[63]
  input  logic [63:0] s_tdata,
  // op[0]
  input  logic        s_tuser,
  // result item
  output logic        m_tvalid,
  input  logic        m_tready,
  // res_year[11:0] res_month[15:12] res_day[20:16] diff_days[41:21]
  // a_before_b[42] a_equals_b[43] a_valid[44] out_of_range[45] zero[47:46]
  output logic [47:0] m_tdata
);

  // res_year is 12 bits, so the top supported year clips at 4095
  localparam int TOP_YEAR = (MAX_YEAR > 4095) ? 4095 : MAX_YEAR;
  localparam logic signed [ACC_W-1:0] LO_DAY = ACC_W'(days_to_year(int'(MIN_YEAR)));
  localparam logic signed [ACC_W-1:0] HI_DAY = ACC_W'(days_to_year(TOP_YEAR + 1) - 1);

  state_t state, state_next;

  // captured item
  logic               op;
  logic [11:0]        a_year, b_year;
  logic [3:0]         a_month, b_month;
  logic [4:0]         a_day, b_day;
  logic signed [20:0] offset_days;

  // working registers
  logic signed [ACC_W-1:0] acc;     // day accumulator / remainder
  logic signed [ACC_W-1:0] ra;      // day number of A during op 1
  logic [11:0]             yr;      // years left (to days) or years found (to date)
  logic [1:0]              cent;    // century within 400-year cycle
  logic [4:0]              quad;    // 4-year block within century
  logic [1:0]              yidx;    // year within 4-year block
  logic [3:0]              mon;
  logic                    leap;
  logic                    cur_b;   // converting date B
  logic                    moved;
  logic                    oor;
  logic                    a_valid;

  // shared unit
  alu_op_t                 alu_op;
  logic signed [ACC_W-1:0] alu_a, alu_b, alu_res;
  logic                    alu_neg;

  gdod_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .neg (alu_neg)
  );

  // calendar position inside the 400-year cycle
  logic                    short_quad;
  logic                    leap_cur;
  logic signed [ACC_W-1:0] cent_len, quad_len, year_len, mon_len;

  always_comb begin
    short_quad = (quad == 5'd0) && (cent != 2'd0);
    leap_cur   = (yidx == 2'd0) && !short_quad;
    cent_len   = (cent == 2'd0) ? DAYS_CENT_LONG : DAYS_CENT_SHORT;
    quad_len   = short_quad ? DAYS_4Y_SHORT : DAYS_4Y_LONG;
    year_len   = leap_cur ? DAYS_LEAP_YEAR : DAYS_YEAR;
    mon_len    = ACC_W'(month_len(mon, leap));
  end

  // month and day term of the date under conversion: cum days + leap + day - 1
  logic [3:0]         cur_m;
  logic [4:0]         cur_d;
  logic               leap_adj;
  logic signed [10:0] md_term;
  logic               valid_now;

  always_comb begin
    cur_m     = cur_b ? b_month : a_month;
    cur_d     = cur_b ? b_day : a_day;
    leap_adj  = leap && (cur_m > MONTH_FEB);
    md_term   = $signed({2'b00, cum_days(cur_m)}) + $signed({10'd0, leap_adj})
              + $signed({6'd0, cur_d}) - 11'sd1;
    valid_now = (a_year >= MIN_YEAR) && (a_month >= MONTH_JAN) && (a_month <= MONTH_DEC)
             && (a_day != 5'd0) && (a_day <= month_len(a_month, leap));
  end

  // operand select: Y* states add, D* states trial-subtract
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = acc;
    alu_b  = '0;
    case (state)
      S_Y400: begin
        alu_op = ALU_ADD;
        alu_b  = DAYS_400Y;
      end
      S_Y100: begin
        alu_op = ALU_ADD;
        alu_b  = cent_len;
      end
      S_Y4: begin
        alu_op = ALU_ADD;
        alu_b  = quad_len;
      end
      S_Y1: begin
        alu_op = ALU_ADD;
        alu_b  = year_len;
      end
      S_MD: begin
        alu_op = ALU_ADD;
        alu_b  = {{(ACC_W-11){md_term[10]}}, md_term};
      end
      S_OFF: begin
        alu_op = ALU_ADD;
        alu_b  = {{(ACC_W-21){offset_days[20]}}, offset_days};
      end
      S_LO:   alu_b = LO_DAY;
      S_HI: begin
        alu_a = HI_DAY;
        alu_b = acc;
      end
      S_SUB: begin
        alu_a = ra;
        alu_b = acc;
      end
      S_D400: alu_b = DAYS_400Y;
      S_D100: alu_b = cent_len;
      S_D4:   alu_b = quad_len;
      S_D1:   alu_b = year_len;
      S_DMON: alu_b = mon_len;
      default: alu_b = '0;
    endcase
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) begin
        state_next = S_Y400;
      end
      S_Y400: if (yr < YEARS_400) begin
        state_next = S_Y100;
      end
      S_Y100: if (yr < YEARS_100) begin
        state_next = S_Y4;
      end
      S_Y4: if (yr < YEARS_4) begin
        state_next = S_Y1;
      end
      S_Y1: if (yr == 12'd0) begin
        state_next = S_MD;
      end
      S_MD: begin
        if (cur_b) begin
          state_next = S_SUB;
        end else if (op) begin
          state_next = S_Y400;
        end else if (valid_now) begin
          state_next = S_OFF;
        end else begin
          state_next = S_DONE;
        end
      end
      S_OFF:  state_next = S_LO;
      S_LO:   state_next = alu_neg ? S_DONE : S_HI;
      S_HI:   state_next = alu_neg ? S_DONE : S_D400;
      S_SUB:  state_next = S_DONE;
      S_D400: if (alu_neg) begin
        state_next = S_D100;
      end
      S_D100: if (alu_neg || cent == 2'd3) begin
        state_next = S_D4;
      end
      S_D4: if (alu_neg) begin
        state_next = S_D1;
      end
      S_D1: if (alu_neg || yidx == 2'd3) begin
        state_next = S_DMON;
      end
      S_DMON: if (alu_neg || mon == MONTH_DEC) begin
        state_next = S_DONE;
      end
      S_DONE: if (out_free) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (s_tvalid) begin
        op          <= s_tuser;
        a_year      <= s_tdata[11:0];
        a_month     <= s_tdata[15:12];
        a_day       <= s_tdata[20:16];
        b_year      <= s_tdata[32:21];
        b_month     <= s_tdata[36:33];
        b_day       <= s_tdata[41:37];
        offset_days <= $signed(s_tdata[62:42]);
        acc         <= '0;
        yr          <= s_tdata[11:0];
        cent        <= '0;
        quad        <= '0;
        yidx        <= '0;
        cur_b       <= 1'b0;
        moved       <= 1'b0;
        oor         <= 1'b0;
      end
      S_Y400: if (yr >= YEARS_400) begin
        acc <= alu_res;
        yr  <= yr - YEARS_400;
      end
      S_Y100: if (yr >= YEARS_100) begin
        acc  <= alu_res;
        yr   <= yr - YEARS_100;
        cent <= cent + 2'd1;
      end
      S_Y4: if (yr >= YEARS_4) begin
        acc  <= alu_res;
        yr   <= yr - YEARS_4;
        quad <= quad + 5'd1;
      end
      S_Y1: begin
        if (yr != 12'd0) begin
          acc  <= alu_res;
          yr   <= yr - 12'd1;
          yidx <= yidx + 2'd1;
        end else begin
          leap <= leap_cur;
        end
      end
      S_MD: begin
        if (!cur_b) begin
          a_valid <= valid_now;
        end
        if (!cur_b && op) begin
          // park A, start over on B
          ra    <= alu_res;
          acc   <= '0;
          yr    <= b_year;
          cent  <= '0;
          quad  <= '0;
          yidx  <= '0;
          cur_b <= 1'b1;
        end else begin
          acc <= alu_res;
        end
      end
      S_OFF: acc <= alu_res;
      S_LO: if (alu_neg) begin
        oor <= 1'b1;
      end
      S_HI: begin
        if (alu_neg) begin
          oor <= 1'b1;
        end else begin
          yr   <= '0;
          cent <= '0;
          quad <= '0;
          yidx <= '0;
        end
      end
      S_SUB: acc <= alu_res;
      S_D400: if (!alu_neg) begin
        acc <= alu_res;
        yr  <= yr + YEARS_400;
      end
      S_D100: if (!alu_neg && cent != 2'd3) begin
        acc  <= alu_res;
        yr   <= yr + YEARS_100;
        cent <= cent + 2'd1;
      end
      S_D4: if (!alu_neg) begin
        acc  <= alu_res;
        yr   <= yr + YEARS_4;
        quad <= quad + 5'd1;
      end
      S_D1: begin
        if (!alu_neg && yidx != 2'd3) begin
          acc  <= alu_res;
          yr   <= yr + 12'd1;
          yidx <= yidx + 2'd1;
        end else begin
          leap <= leap_cur;
          mon  <= MONTH_JAN;
        end
      end
      S_DMON: begin
        if (!alu_neg && mon != MONTH_DEC) begin
          acc <= alu_res;
          mon <= mon + 4'd1;
        end else begin
          moved <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result assembly
  logic [11:0] res_year;
  logic [3:0]  res_month;
  logic [4:0]  res_day;
  logic [20:0] diff_days;
  logic        a_before_b, a_equals_b, months_ok;

  always_comb begin
    res_year   = moved ? yr : a_year;
    res_month  = moved ? mon : a_month;
    res_day    = moved ? (acc[4:0] + 5'd1) : a_day;
    months_ok  = (a_month >= MONTH_JAN) && (a_month <= MONTH_DEC)
              && (b_month >= MONTH_JAN) && (b_month <= MONTH_DEC);
    if (!op || !months_ok) begin
      diff_days = '0;
    end else if (acc > DIFF_MAX) begin
      diff_days = DIFF_MAX[20:0];
    end else if (acc < DIFF_MIN) begin
      diff_days = DIFF_MIN[20:0];
    end else begin
      diff_days = acc[20:0];
    end
    a_equals_b = (a_year == b_year) && (a_month == b_month) && (a_day == b_day);
    a_before_b = (a_year < b_year)
              || ((a_year == b_year) && ((a_month < b_month)
              || ((a_month == b_month) && (a_day < b_day))));
  end

  // output register, parks one result so the next item can be taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {2'b00, oor, a_valid, a_equals_b, a_before_b, diff_days,
                  res_day, res_month, res_year};
    end
  end

  // checks
  `GDOD_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready, state != S_IDLE, "item not started")
  `GDOD_ASSERT_NXT(a_done_loads, state == S_DONE && out_free, m_tvalid, "result not presented")
  `GDOD_ASSERT_IMP(a_oor_flags, m_tvalid && m_tdata[45], m_tdata[44] && !(|m_tdata[41:21]), "oor")

endmodule
